[rtl/wnb_pkg.sv]
`timescale 1ns / 1ps

package wnb_pkg;

  typedef struct packed {
    logic        action;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [23:0] min_sq_distance;
    logic [15:0] distance_q4;
    logic [1:0]  status;
  } res_t;

  localparam logic       ACT_BUILD = 1'b0;
  localparam logic       ACT_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADCFG = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BOXES  = 3'd2;
  localparam logic [2:0] REG_POINTS = 3'd3;
  localparam logic [2:0] REG_SEED   = 3'd4;

  localparam logic [12:0] RST_WIDTH  = 13'd256;
  localparam logic [12:0] RST_HEIGHT = 13'd256;
  localparam logic [4:0]  RST_BOXES  = 5'd4;
  localparam logic [3:0]  RST_POINTS = 4'd1;

  // pcg-xsh-rs step constants and cell seed mixing constants
  localparam logic [63:0] GEN_MUL = 64'd314159265358979323;
  localparam logic [63:0] GEN_INC = 64'd462643383279584626;
  localparam logic [31:0] ROW_MUL = 32'hdeadbeef;
  localparam logic [31:0] COL_MUL = 32'hc00cf00d;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BX_GO,
    ST_BX_WAIT,
    ST_BY_GO,
    ST_BY_WAIT,
    ST_B_T0,
    ST_B_T1,
    ST_B_T2,
    ST_B_CELL,
    ST_B_G0,
    ST_B_G1,
    ST_B_G2,
    ST_B_G3,
    ST_B_OFF0,
    ST_B_OFF1,
    ST_Q_DY_GO,
    ST_Q_DY_WAIT,
    ST_Q_DX_GO,
    ST_Q_DX_WAIT,
    ST_Q_NP0,
    ST_Q_NP1,
    ST_Q_ROW0,
    ST_Q_ROW1,
    ST_Q_CELL0,
    ST_Q_CELL1,
    ST_Q_PTS,
    ST_Q_DRAIN,
    ST_Q_SQ_GO,
    ST_Q_SQ_WAIT
  } state_e;

  // xorshift output with random rotation-free shift
  function automatic logic [31:0] gen_out(input logic [63:0] s);
    logic [63:0] x;
    logic [5:0]  sh;
    x  = s ^ (s >> 22);
    sh = 6'd22 + {3'b000, s[63:61]};
    return 32'(x >> sh);
  endfunction

endpackage

[rtl/wnb_div.sv]
`timescale 1ns / 1ps

module wnb_div #(
  parameter int W = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[W-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CNTW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step, one quotient bit a cycle
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/wnb_sqrt.sv]
`timescale 1ns / 1ps

module wnb_sqrt #(
  parameter int W = 34
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   rad_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);

  localparam int HW   = W / 2;
  localparam int CNTW = $clog2(HW + 1);

  logic [W-1:0]    rad_q, rad_d;
  logic [HW:0]     rem_q, rem_d;
  logic [HW-1:0]   root_q, root_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [HW+2:0]   r2, trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r2     = {rem_q, rad_q[W-1:W-2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNTW'(HW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one root bit a cycle, two radicand bits consumed
      rad_d = {rad_q[W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_d  = (HW+1)'(r2 - trial);
        root_d = {root_q[HW-2:0], 1'b1};
      end else begin
        rem_d  = (HW+1)'(r2);
        root_d = {root_q[HW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/worley_noise_boxed_wrapped.sv]
`timescale 1ns / 1ps

// Tileable Worley (F1) noise over a boxed feature-point table. A request is
// taken when start is high and busy is low; each request gives exactly one
// result, shown on res_o for one cycle with res_valid_o high, and the
// receiver cannot stall it, so it must take the result in that cycle. A
// build request fills the point table cell by cell: a 64-bit generator
// step runs as three 32x32 partial products on one shared multiplier. A
// query request runs four divisions (box size and cell index), then the
// 3x3 neighbour cells are streamed from the table one point a cycle within
// each cell into a distance pipeline, then a bit-serial square root. The
// table holds no reset value; a query is refused with bad-configuration
// status until a build has completed since the last register write.
// Registers sit at 8-byte steps on the configuration port and must only
// be written while busy is low.

module worley_noise_boxed_wrapped #(
  parameter int MAX_BOXES  = 16,
  parameter int MAX_POINTS = 8,
  parameter int COORD_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  wnb_pkg::req_t req_i,
  output logic          busy,
  output logic          res_valid_o,
  output wnb_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int CB    = COORD_BITS;
  localparam int DEPTH = MAX_BOXES * MAX_BOXES * MAX_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_BOXES + 1);
  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int BW    = 2 * CB + 1;
  localparam int SW    = 2 * CB + 10;
  localparam int RTW   = SW / 2;
  localparam int LIM   = 1 << CB;

  // configuration registers
  logic [12:0] width_q, height_q;
  logic [4:0]  nb_q;
  logic [3:0]  np_q;
  logic [63:0] seed_q;
  logic        cfg_wr;
  logic        cfg_ok;

  // control
  wnb_pkg::state_e state_q, state_d;
  wnb_pkg::req_t   req_q;
  wnb_pkg::res_t   res_q, res_d;
  logic            res_vld_q, res_vld_d;
  logic            built_q, built_d;

  // geometry
  logic [12:0]   bx_q, bx_d, by_q, by_d;
  logic [CW-1:0] xb_q, xb_d, yb_q, yb_d;

  // build sequencer
  logic [63:0]   t_q, t_d, acc_q, acc_d, rowseed_q, rowseed_d;
  logic [31:0]   colseed_q, colseed_d;
  logic [63:0]   st_q, st_d, s_q, s_d, snew, acc_nx;
  logic [31:0]   rand_q, rand_d;
  logic          ydraw_q, ydraw_d;
  logic [CB-1:0] px_q, px_d, xorg_q, xorg_d, yorg_q, yorg_d, coord;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [PW-1:0] n_q, n_d;
  logic [AW-1:0] waddr_q, waddr_d;

  // query sequencer
  logic [AW:0]   nbnp_q, nbnp_d;
  logic [AW-1:0] rowbase_q, rowbase_d, raddr_q, raddr_d;
  logic [CW-1:0] cr_q, cr_d, cc_q, cc_d, cc0_q, cc0_d, ym, xm;
  logic [1:0]    dx_q, dx_d, dy_q, dy_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_q;

  // point table
  logic [2*CB-1:0] tbl_mem [DEPTH];
  logic            tbl_we;
  logic [2*CB-1:0] tbl_wdata;
  logic            rd_en;
  logic [2*CB-1:0] rdata_q;

  // distance pipeline
  logic          rd_vld_q, v1_q, v2_q;
  logic [CB-1:0] dxd_q, dyd_q, pix_x, pix_y;
  logic [2*CB-1:0] sqx_q, sqy_q;
  logic [BW-1:0] best_q, dsum;
  logic          best_clr;

  // iterative units
  logic        div_start, div_done;
  logic [12:0] div_num, div_den, div_quo;
  logic        sq_start, sq_done;
  logic [RTW-1:0] sq_root;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_q != wnb_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wnb_pkg::RST_WIDTH;
      height_q <= wnb_pkg::RST_HEIGHT;
      nb_q     <= wnb_pkg::RST_BOXES;
      np_q     <= wnb_pkg::RST_POINTS;
      seed_q   <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        wnb_pkg::REG_WIDTH:  width_q  <= pwdata[12:0];
        wnb_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
        wnb_pkg::REG_BOXES:  nb_q     <= pwdata[4:0];
        wnb_pkg::REG_POINTS: np_q     <= pwdata[3:0];
        wnb_pkg::REG_SEED:   seed_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      wnb_pkg::REG_WIDTH:  prdata = {51'b0, width_q};
      wnb_pkg::REG_HEIGHT: prdata = {51'b0, height_q};
      wnb_pkg::REG_BOXES:  prdata = {59'b0, nb_q};
      wnb_pkg::REG_POINTS: prdata = {60'b0, np_q};
      wnb_pkg::REG_SEED:   prdata = seed_q;
      default:             prdata = '0;
    endcase
  end

  // box size of zero shows up as a dimension below the box count
  assign cfg_ok = (width_q != '0) && (32'(width_q) <= LIM) &&
                  (height_q != '0) && (32'(height_q) <= LIM) &&
                  (nb_q != '0) && (32'(nb_q) <= MAX_BOXES) &&
                  (np_q != '0) && (32'(np_q) <= MAX_POINTS) &&
                  (width_q >= 13'(nb_q)) && (height_q >= 13'(nb_q));

  // query pixel, valid once the range check has passed
  assign pix_x = CB'(req_q.pixel_x);
  assign pix_y = CB'(req_q.pixel_y);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    built_d   = built_q;
    bx_d      = bx_q;
    by_d      = by_q;
    xb_d      = xb_q;
    yb_d      = yb_q;
    t_d       = t_q;
    acc_d     = acc_q;
    rowseed_d = rowseed_q;
    colseed_d = colseed_q;
    st_d      = st_q;
    s_d       = s_q;
    rand_d    = rand_q;
    ydraw_d   = ydraw_q;
    px_d      = px_q;
    xorg_d    = xorg_q;
    yorg_d    = yorg_q;
    row_d     = row_q;
    col_d     = col_q;
    n_d       = n_q;
    waddr_d   = waddr_q;
    nbnp_d    = nbnp_q;
    rowbase_d = rowbase_q;
    raddr_d   = raddr_q;
    cr_d      = cr_q;
    cc_d      = cc_q;
    cc0_d     = cc0_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = width_q;
    div_den   = 13'(nb_q);
    sq_start  = 1'b0;
    tbl_we    = 1'b0;
    rd_en     = 1'b0;
    best_clr  = 1'b0;
    snew      = s_q + {mul_p_q[31:0], 32'b0} + wnb_pkg::GEN_INC;
    acc_nx    = acc_q + t_q;
    coord     = CB'(mul_p_q[63:32]) + (ydraw_q ? yorg_q : xorg_q);
    tbl_wdata = {coord, px_q};
    // cell index stays below twice the box count, one subtraction wraps it
    ym        = (yb_q >= CW'(nb_q)) ? CW'(yb_q - CW'(nb_q)) : yb_q;
    xm        = (xb_q >= CW'(nb_q)) ? CW'(xb_q - CW'(nb_q)) : xb_q;

    case (state_q)
      wnb_pkg::ST_IDLE: begin
        if (accept) state_d = wnb_pkg::ST_CHECK;
      end

      wnb_pkg::ST_CHECK: begin
        res_d.min_sq_distance = '0;
        res_d.distance_q4     = '0;
        res_d.status          = wnb_pkg::STATUS_OK;
        if (req_q.action == wnb_pkg::ACT_BUILD) begin
          if (!cfg_ok) begin
            built_d      = 1'b0;
            res_d.status = wnb_pkg::STATUS_BADCFG;
            res_vld_d    = 1'b1;
            state_d      = wnb_pkg::ST_IDLE;
          end else begin
            state_d = wnb_pkg::ST_BX_GO;
          end
        end else if (!cfg_ok || !built_q) begin
          res_d.status = wnb_pkg::STATUS_BADCFG;
          res_vld_d    = 1'b1;
          state_d      = wnb_pkg::ST_IDLE;
        end else if (({1'b0, req_q.pixel_x} >= width_q) ||
                     ({1'b0, req_q.pixel_y} >= height_q)) begin
          res_d.status = wnb_pkg::STATUS_RANGE;
          res_vld_d    = 1'b1;
          state_d      = wnb_pkg::ST_IDLE;
        end else begin
          state_d = wnb_pkg::ST_BX_GO;
        end
      end

      // box size in each axis
      wnb_pkg::ST_BX_GO: begin
        div_start = 1'b1;
        state_d   = wnb_pkg::ST_BX_WAIT;
      end
      wnb_pkg::ST_BX_WAIT: begin
        if (div_done) begin
          bx_d    = div_quo;
          state_d = wnb_pkg::ST_BY_GO;
        end
      end
      wnb_pkg::ST_BY_GO: begin
        div_start = 1'b1;
        div_num   = height_q;
        state_d   = wnb_pkg::ST_BY_WAIT;
      end
      wnb_pkg::ST_BY_WAIT: begin
        if (div_done) begin
          by_d    = div_quo;
          state_d = (req_q.action == wnb_pkg::ACT_BUILD) ? wnb_pkg::ST_B_T0
                                                         : wnb_pkg::ST_Q_DY_GO;
        end
      end

      // row seed step: seed * 0xdeadbeef mod 2^64, added once per cell
      wnb_pkg::ST_B_T0: begin
        mul_a   = seed_q[31:0];
        mul_b   = wnb_pkg::ROW_MUL;
        state_d = wnb_pkg::ST_B_T1;
      end
      wnb_pkg::ST_B_T1: begin
        mul_a   = seed_q[63:32];
        mul_b   = wnb_pkg::ROW_MUL;
        t_d     = mul_p_q;
        state_d = wnb_pkg::ST_B_T2;
      end
      wnb_pkg::ST_B_T2: begin
        t_d       = t_q + {mul_p_q[31:0], 32'b0};
        acc_d     = '0;
        rowseed_d = '0;
        colseed_d = '0;
        row_d     = '0;
        col_d     = '0;
        xorg_d    = '0;
        yorg_d    = '0;
        waddr_d   = '0;
        state_d   = wnb_pkg::ST_B_CELL;
      end

      wnb_pkg::ST_B_CELL: begin
        st_d    = rowseed_q + {32'b0, colseed_q};
        n_d     = '0;
        ydraw_d = 1'b0;
        state_d = wnb_pkg::ST_B_G0;
      end

      // generator step as three partial products
      wnb_pkg::ST_B_G0: begin
        mul_a   = st_q[31:0];
        mul_b   = wnb_pkg::GEN_MUL[31:0];
        state_d = wnb_pkg::ST_B_G1;
      end
      wnb_pkg::ST_B_G1: begin
        mul_a   = st_q[31:0];
        mul_b   = wnb_pkg::GEN_MUL[63:32];
        s_d     = mul_p_q;
        state_d = wnb_pkg::ST_B_G2;
      end
      wnb_pkg::ST_B_G2: begin
        mul_a   = st_q[63:32];
        mul_b   = wnb_pkg::GEN_MUL[31:0];
        s_d     = s_q + {mul_p_q[31:0], 32'b0};
        state_d = wnb_pkg::ST_B_G3;
      end
      wnb_pkg::ST_B_G3: begin
        st_d    = snew;
        rand_d  = wnb_pkg::gen_out(snew);
        state_d = wnb_pkg::ST_B_OFF0;
      end

      // offset = (rand * box) >> 32, plus cell origin
      wnb_pkg::ST_B_OFF0: begin
        mul_a   = rand_q;
        mul_b   = 32'(ydraw_q ? by_q : bx_q);
        state_d = wnb_pkg::ST_B_OFF1;
      end
      wnb_pkg::ST_B_OFF1: begin
        if (!ydraw_q) begin
          px_d    = coord;
          ydraw_d = 1'b1;
          state_d = wnb_pkg::ST_B_G0;
        end else begin
          tbl_we  = 1'b1;
          waddr_d = waddr_q + 1'b1;
          ydraw_d = 1'b0;
          n_d     = n_q + 1'b1;
          state_d = wnb_pkg::ST_B_G0;
          if (n_q == PW'(np_q - 4'd1)) begin
            acc_d     = acc_nx;
            colseed_d = colseed_q + wnb_pkg::COL_MUL;
            xorg_d    = xorg_q + CB'(bx_q);
            col_d     = col_q + 1'b1;
            state_d   = wnb_pkg::ST_B_CELL;
            if (col_q == CW'(nb_q - 5'd1)) begin
              col_d     = '0;
              colseed_d = '0;
              xorg_d    = '0;
              rowseed_d = acc_nx;
              yorg_d    = yorg_q + CB'(by_q);
              row_d     = row_q + 1'b1;
              if (row_q == CW'(nb_q - 5'd1)) begin
                built_d               = 1'b1;
                res_d.min_sq_distance = '0;
                res_d.distance_q4     = '0;
                res_d.status          = wnb_pkg::STATUS_OK;
                res_vld_d             = 1'b1;
                state_d               = wnb_pkg::ST_IDLE;
              end
            end
          end
        end
      end

      // cell of the pixel
      wnb_pkg::ST_Q_DY_GO: begin
        div_start = 1'b1;
        div_num   = 13'(req_q.pixel_y);
        div_den   = by_q;
        state_d   = wnb_pkg::ST_Q_DY_WAIT;
      end
      wnb_pkg::ST_Q_DY_WAIT: begin
        if (div_done) begin
          yb_d    = CW'(div_quo);
          state_d = wnb_pkg::ST_Q_DX_GO;
        end
      end
      wnb_pkg::ST_Q_DX_GO: begin
        div_start = 1'b1;
        div_num   = 13'(req_q.pixel_x);
        div_den   = bx_q;
        state_d   = wnb_pkg::ST_Q_DX_WAIT;
      end
      wnb_pkg::ST_Q_DX_WAIT: begin
        if (div_done) begin
          xb_d    = CW'(div_quo);
          state_d = wnb_pkg::ST_Q_NP0;
        end
      end

      wnb_pkg::ST_Q_NP0: begin
        mul_a    = 32'(nb_q);
        mul_b    = 32'(np_q);
        best_clr = 1'b1;
        state_d  = wnb_pkg::ST_Q_NP1;
      end
      wnb_pkg::ST_Q_NP1: begin
        nbnp_d  = (AW+1)'(mul_p_q);
        // neighbour ring starts one cell up and left, wrapped
        cr_d    = (ym == '0) ? CW'(nb_q - 5'd1) : ym - 1'b1;
        cc0_d   = (xm == '0) ? CW'(nb_q - 5'd1) : xm - 1'b1;
        dy_d    = '0;
        state_d = wnb_pkg::ST_Q_ROW0;
      end
      wnb_pkg::ST_Q_ROW0: begin
        mul_a   = 32'(cr_q);
        mul_b   = 32'(nbnp_q);
        cc_d    = cc0_q;
        dx_d    = '0;
        state_d = wnb_pkg::ST_Q_ROW1;
      end
      wnb_pkg::ST_Q_ROW1: begin
        rowbase_d = AW'(mul_p_q);
        state_d   = wnb_pkg::ST_Q_CELL0;
      end
      wnb_pkg::ST_Q_CELL0: begin
        mul_a   = 32'(cc_q);
        mul_b   = 32'(np_q);
        state_d = wnb_pkg::ST_Q_CELL1;
      end
      wnb_pkg::ST_Q_CELL1: begin
        raddr_d = rowbase_q + AW'(mul_p_q);
        n_d     = '0;
        state_d = wnb_pkg::ST_Q_PTS;
      end

      // one table read a cycle into the distance pipeline
      wnb_pkg::ST_Q_PTS: begin
        rd_en   = 1'b1;
        raddr_d = raddr_q + 1'b1;
        n_d     = n_q + 1'b1;
        if (n_q == PW'(np_q - 4'd1)) begin
          if (dx_q == 2'd2) begin
            if (dy_q == 2'd2) begin
              state_d = wnb_pkg::ST_Q_DRAIN;
            end else begin
              dy_d    = dy_q + 1'b1;
              cr_d    = (CW'(cr_q + 1'b1) == CW'(nb_q)) ? '0 : cr_q + 1'b1;
              state_d = wnb_pkg::ST_Q_ROW0;
            end
          end else begin
            dx_d    = dx_q + 1'b1;
            cc_d    = (CW'(cc_q + 1'b1) == CW'(nb_q)) ? '0 : cc_q + 1'b1;
            state_d = wnb_pkg::ST_Q_CELL0;
          end
        end
      end
      wnb_pkg::ST_Q_DRAIN: begin
        if (!rd_vld_q && !v1_q && !v2_q) state_d = wnb_pkg::ST_Q_SQ_GO;
      end

      wnb_pkg::ST_Q_SQ_GO: begin
        sq_start = 1'b1;
        state_d  = wnb_pkg::ST_Q_SQ_WAIT;
      end
      wnb_pkg::ST_Q_SQ_WAIT: begin
        if (sq_done) begin
          res_d.min_sq_distance = (best_q > BW'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(best_q);
          res_d.distance_q4     = (sq_root > RTW'(16'hFFFF)) ? 16'hFFFF : 16'(sq_root);
          res_d.status          = wnb_pkg::STATUS_OK;
          res_vld_d             = 1'b1;
          state_d               = wnb_pkg::ST_IDLE;
        end
      end

      default: state_d = wnb_pkg::ST_IDLE;
    endcase

    // any register write leaves the table stale
    if (cfg_wr && (paddr[5:3] == wnb_pkg::REG_WIDTH || paddr[5:3] == wnb_pkg::REG_HEIGHT ||
                   paddr[5:3] == wnb_pkg::REG_BOXES || paddr[5:3] == wnb_pkg::REG_POINTS ||
                   paddr[5:3] == wnb_pkg::REG_SEED)) begin
      built_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wnb_pkg::ST_IDLE;
      res_vld_q <= 1'b0;
      built_q   <= 1'b0;
      st_q      <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      built_q   <= built_d;
      st_q      <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    res_q     <= res_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    xb_q      <= xb_d;
    yb_q      <= yb_d;
    t_q       <= t_d;
    acc_q     <= acc_d;
    rowseed_q <= rowseed_d;
    colseed_q <= colseed_d;
    s_q       <= s_d;
    rand_q    <= rand_d;
    ydraw_q   <= ydraw_d;
    px_q      <= px_d;
    xorg_q    <= xorg_d;
    yorg_q    <= yorg_d;
    row_q     <= row_d;
    col_q     <= col_d;
    n_q       <= n_d;
    waddr_q   <= waddr_d;
    nbnp_q    <= nbnp_d;
    rowbase_q <= rowbase_d;
    raddr_q   <= raddr_d;
    cr_q      <= cr_d;
    cc_q      <= cc_d;
    cc0_q     <= cc0_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    mul_p_q   <= mul_a * mul_b;
  end

  // point table: x in the low half, y in the high half
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[waddr_q] <= tbl_wdata;
    if (rd_en) rdata_q <= tbl_mem[raddr_q];
  end

  // ---------------------------------------------------------------------
  // distance pipeline: wrap distances, squares, running minimum
  // ---------------------------------------------------------------------
  function automatic logic [CB-1:0] wrap_d(input logic [CB-1:0] p, input logic [CB-1:0] q,
                                           input logic [CB:0] per);
    logic [CB-1:0] d;
    d = (p > q) ? p - q : q - p;
    if ({d, 1'b0} > per) d = CB'(per - {1'b0, d});
    return d;
  endfunction

  assign dsum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      v1_q     <= rd_vld_q;
      v2_q     <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxd_q <= wrap_d(pix_x, rdata_q[CB-1:0], (CB+1)'(width_q));
    dyd_q <= wrap_d(pix_y, rdata_q[2*CB-1:CB], (CB+1)'(height_q));
    sqx_q <= dxd_q * dxd_q;
    sqy_q <= dyd_q * dyd_q;
    if (best_clr) begin
      best_q <= '1;
    end else if (v2_q && (dsum < best_q)) begin
      best_q <= dsum;
    end
  end

  // ---------------------------------------------------------------------
  // iterative units
  // ---------------------------------------------------------------------
  wnb_div #(
    .W(13)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // distance scaled by 256 gives four fraction bits of root
  wnb_sqrt #(
    .W(SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (SW'({best_q, 8'b0})),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

[rtl/wnb_checker.sv]
`timescale 1ns / 1ps

module wnb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input wnb_pkg::res_t res_o
);

  // an accepted request always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // a result only closes a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy && $past(busy))
    else $error("result outside the end of a request");

  // the block never goes idle without a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("request finished without a result");

  // error results carry zero distances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != wnb_pkg::STATUS_OK |->
      res_o.min_sq_distance == '0 && res_o.distance_q4 == '0)
    else $error("error result with nonzero distance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.status == wnb_pkg::STATUS_OK ||
                    res_o.status == wnb_pkg::STATUS_BADCFG ||
                    res_o.status == wnb_pkg::STATUS_RANGE)
    else $error("undefined status code");

endmodule

bind worley_noise_boxed_wrapped wnb_checker u_wnb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

[sim/worley_noise_boxed_wrapped_tb.sv]
`timescale 1ns / 1ps

module worley_noise_boxed_wrapped_tb;

  localparam int NBOX_MAX  = 16;
  localparam int NPT_MAX   = 8;
  localparam int TBL_DEPTH = NBOX_MAX * NBOX_MAX * NPT_MAX;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  wnb_pkg::req_t req_i;
  logic          busy;
  logic          res_valid_o;
  wnb_pkg::res_t res_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [5:0]    paddr;
  logic [63:0]   pwdata;
  logic [63:0]   prdata;
  logic          pready;

  worley_noise_boxed_wrapped DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // shadow copy of the block: registers, point table and generator
  logic [12:0] img_w, img_h;
  logic [4:0]  nboxes;
  logic [3:0]  npoints;
  logic [63:0] seed_reg;
  logic [23:0] point_mem [TBL_DEPTH];
  logic        points_valid;
  logic [63:0] pcg_state;

  wnb_pkg::res_t expected_results[$];
  int   mismatches;
  int   results_seen;
  int   builds_sent;
  int   queries_sent;
  int   gap_pct;

  // clock, 2 ns period
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // one pcg-xsh-rs step on the shadow generator
  function automatic logic [31:0] pcg_draw();
    logic [63:0] s;
    logic [63:0] mixed;
    s = pcg_state * wnb_pkg::GEN_MUL + wnb_pkg::GEN_INC;
    mixed = (s ^ (s >> 22)) >> (22 + s[63:61]);
    pcg_state = s;
    return mixed[31:0];
  endfunction

  function automatic bit cfg_valid();
    if (img_w == 0 || img_w > 13'd4096) return 0;
    if (img_h == 0 || img_h > 13'd4096) return 0;
    if (nboxes == 0 || nboxes > NBOX_MAX) return 0;
    if (npoints == 0 || npoints > NPT_MAX) return 0;
    if (img_w / nboxes == 0 || img_h / nboxes == 0) return 0;
    return 1;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned torus_delta(input int unsigned p, input int unsigned q,
                                                  input int unsigned period);
    longint unsigned d;
    d = (p > q) ? p - q : q - p;
    if (2 * d > period) d = period - d;
    return d;
  endfunction

  // fill the shadow table the way a build does
  function automatic void scatter_points();
    int unsigned bx, by, idx;
    logic [31:0] col_mix;
    logic [63:0] prod_x, prod_y;
    logic [31:0] px, py;
    bx = img_w / nboxes;
    by = img_h / nboxes;
    for (int unsigned row = 0; row < nboxes; row++) begin
      for (int unsigned col = 0; col < nboxes; col++) begin
        col_mix = col * wnb_pkg::COL_MUL;
        pcg_state = seed_reg * 64'(row) * 64'(nboxes) * 64'(wnb_pkg::ROW_MUL) + 64'(col_mix);
        for (int unsigned n = 0; n < npoints; n++) begin
          prod_x = 64'(pcg_draw()) * 64'(bx);
          prod_y = 64'(pcg_draw()) * 64'(by);
          px = prod_x[63:32] + bx * col;
          py = prod_y[63:32] + by * row;
          idx = (row * nboxes + col) * npoints + n;
          if (idx < TBL_DEPTH) point_mem[idx] = {py[11:0], px[11:0]};
        end
      end
    end
    points_valid = 1'b1;
  endfunction

  // expected result of one request, updates the shadow state
  function automatic wnb_pkg::res_t nearest_point(input wnb_pkg::req_t rq);
    wnb_pkg::res_t r;
    int unsigned xb, yb, cr, cc, idx, x, y;
    longint unsigned best, d, q;
    r = '0;
    x = rq.pixel_x;
    y = rq.pixel_y;
    if (rq.action == wnb_pkg::ACT_BUILD) begin
      if (!cfg_valid()) begin
        points_valid = 1'b0;
        r.status = wnb_pkg::STATUS_BADCFG;
      end else begin
        scatter_points();
      end
      return r;
    end
    if (!cfg_valid() || !points_valid) begin
      r.status = wnb_pkg::STATUS_BADCFG;
      return r;
    end
    if (x >= img_w || y >= img_h) begin
      r.status = wnb_pkg::STATUS_RANGE;
      return r;
    end
    xb = x / (img_w / nboxes);
    yb = y / (img_h / nboxes);
    best = '1;
    for (int unsigned dy = 0; dy < 3; dy++) begin
      for (int unsigned dx = 0; dx < 3; dx++) begin
        cr = (yb + dy + nboxes - 1) % nboxes;
        cc = (xb + dx + nboxes - 1) % nboxes;
        for (int unsigned n = 0; n < npoints; n++) begin
          idx = (cr * nboxes + cc) * npoints + n;
          if (idx < TBL_DEPTH) begin
            d = torus_delta(x, point_mem[idx][11:0], img_w) ** 2
              + torus_delta(y, point_mem[idx][23:12], img_h) ** 2;
            if (d < best) best = d;
          end
        end
      end
    end
    if (best == 64'hFFFF_FFFF_FFFF_FFFF) best = 0;
    q = floor_sqrt(best << 8);
    r.min_sq_distance = (best > 64'hFF_FFFF) ? 24'hFF_FFFF : best[23:0];
    r.distance_q4 = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    return r;
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_request(input logic act, input logic [11:0] x, input logic [11:0] y);
    wnb_pkg::req_t rq;
    rq.action = act;
    rq.pixel_x = x;
    rq.pixel_y = y;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(nearest_point(rq));
    if (act == wnb_pkg::ACT_BUILD) builds_sent++;
    else queries_sent++;
    // random idle after the request, sometimes long enough to cover a whole query
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(7) == 0 ? $urandom_range(20, 200) : $urandom_range(1, 4))
        @(posedge clk_i);
    end
  endtask

  // wait until every outstanding request has produced its result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0 || busy);
  endtask

  // apb write: setup cycle then access cycle, register written at end of access
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wnb_pkg::REG_WIDTH:  img_w = val[12:0];
      wnb_pkg::REG_HEIGHT: img_h = val[12:0];
      wnb_pkg::REG_BOXES:  nboxes = val[4:0];
      wnb_pkg::REG_POINTS: npoints = val[3:0];
      wnb_pkg::REG_SEED:   seed_reg = val;
      default: ;
    endcase
    points_valid = 1'b0;
  endtask

  task automatic set_config(input logic [12:0] w, input logic [12:0] h, input logic [4:0] nb,
                            input logic [3:0] np, input logic [63:0] sd);
    write_reg(wnb_pkg::REG_WIDTH, 64'(w));
    write_reg(wnb_pkg::REG_HEIGHT, 64'(h));
    write_reg(wnb_pkg::REG_BOXES, 64'(nb));
    write_reg(wnb_pkg::REG_POINTS, 64'(np));
    write_reg(wnb_pkg::REG_SEED, sd);
  endtask

  // result checker, results cannot be stalled so every strobe is taken
  always @(posedge clk_i) begin
    wnb_pkg::res_t exp_r;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (res_o.min_sq_distance !== exp_r.min_sq_distance ||
            res_o.distance_q4 !== exp_r.distance_q4 || res_o.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: dist2 exp %0d got %0d, q4 exp %0d got %0d, status exp %0d got %0d",
                     exp_r.min_sq_distance, res_o.min_sq_distance, exp_r.distance_q4,
                     res_o.distance_q4, exp_r.status, res_o.status);
        end
      end
    end
  end

  // defaults after reset: refused query, build, corners and out of range pixels
  task automatic test_reset_defaults();
    send_request(wnb_pkg::ACT_QUERY, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd255, 12'd255);
    send_request(wnb_pkg::ACT_QUERY, 12'd256, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd0, 12'd256);
    send_request(wnb_pkg::ACT_QUERY, 12'hFFF, 12'hFFF);
  endtask

  // each bad configuration refuses the build; the zero box size also refuses a query
  task automatic test_bad_config();
    set_config(13'd0, 13'd64, 5'd2, 4'd1, 64'd5);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    write_reg(wnb_pkg::REG_WIDTH, 64'd4097);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    write_reg(wnb_pkg::REG_WIDTH, 64'd3);
    write_reg(wnb_pkg::REG_BOXES, 64'd4);
    // box size of zero
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd1, 12'd1);
    set_config(13'd64, 13'd64, 5'd0, 4'd1, 64'd5);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    write_reg(wnb_pkg::REG_BOXES, 64'd17);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    write_reg(wnb_pkg::REG_BOXES, 64'd2);
    write_reg(wnb_pkg::REG_POINTS, 64'd0);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    write_reg(wnb_pkg::REG_POINTS, 64'd9);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    // valid again but a register write made the table stale
    write_reg(wnb_pkg::REG_POINTS, 64'd2);
    send_request(wnb_pkg::ACT_QUERY, 12'd3, 12'd3);
  endtask

  // largest and smallest images, boxes and point counts
  task automatic test_extremes();
    set_config(13'd4096, 13'd4096, 5'd16, 4'd8, '1);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd0, 12'hFFF);
    send_request(wnb_pkg::ACT_QUERY, 12'hFFF, 12'd0);
    set_config(13'd1, 13'd1, 5'd1, 4'd1, 64'd1);
    send_request(wnb_pkg::ACT_BUILD, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd0, 12'd0);
    send_request(wnb_pkg::ACT_QUERY, 12'd1, 12'd0);
  endtask

  // random configurations, mostly small, each built then queried at random
  task automatic test_random(input int n_items);
    int sent;
    logic [12:0] w, h;
    logic [4:0] nb;
    logic [3:0] np;
    sent = 0;
    while (sent < n_items) begin
      nb = ($urandom_range(9) == 0) ? 5'($urandom_range(7, 16)) : 5'($urandom_range(1, 6));
      np = ($urandom_range(9) == 0) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(1, 3));
      if (nb > 8 && np > 4) np = 4'd2;
      w = ($urandom_range(3) == 0) ? 13'($urandom_range(nb, 4096)) : 13'($urandom_range(nb, 300));
      h = ($urandom_range(3) == 0) ? 13'($urandom_range(nb, 4096)) : 13'($urandom_range(nb, 300));
      set_config(w, h, nb, np, {$urandom, $urandom});
      send_request(wnb_pkg::ACT_BUILD, 12'($urandom), 12'($urandom));
      sent++;
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(9) == 0)
          send_request(wnb_pkg::ACT_QUERY, 12'($urandom), 12'($urandom));
        else if ($urandom_range(49) == 0)
          send_request(wnb_pkg::ACT_BUILD, 12'($urandom), 12'($urandom));
        else
          send_request(wnb_pkg::ACT_QUERY, 12'($urandom_range(w - 1)),
                       12'($urandom_range(h - 1)));
        sent++;
      end
      // hold off new requests until everything outstanding has returned
      if ($urandom_range(3) == 0) drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    img_w = wnb_pkg::RST_WIDTH;
    img_h = wnb_pkg::RST_HEIGHT;
    nboxes = wnb_pkg::RST_BOXES;
    npoints = wnb_pkg::RST_POINTS;
    seed_reg = '0;
    points_valid = 1'b0;
    pcg_state = '0;
    mismatches = 0;
    results_seen = 0;
    builds_sent = 0;
    queries_sent = 0;
    gap_pct = 23;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_bad_config();
    test_extremes();
    gap_pct = 23;
    test_random(260);
    gap_pct = 76;
    test_random(260);
    gap_pct = 0;
    test_random(260);

    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d builds and %0d queries, %0d results checked", builds_sent,
             queries_sent, results_seen);
    $display("including bad configurations, stale tables, out of range pixels and edge sizes");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
